### hdl/csc_pkg.sv
// Shared constants for the curve shape classifier: sizes, derived widths
// and result class codes. No dependencies.
`default_nettype none

package csc_pkg;

   localparam int MAX_SAMPLES   = 64;
   localparam int SAMPLE_BITS   = 16;
   localparam int SLOPE_SPAN    = 4;

   localparam int SAMPLE_IN_BITS = 16;
   localparam int CLASS_BITS     = 2;

   localparam int ADDR_BITS  = $clog2(MAX_SAMPLES);
   localparam int COUNT_BITS = $clog2(MAX_SAMPLES + 1);
   localparam int WIDE_BITS  = COUNT_BITS + 1;
   localparam int DIFF_BITS  = SAMPLE_BITS + 1;

   localparam logic [CLASS_BITS-1:0] CLASS_ONE_HUMP  = 2'd0;
   localparam logic [CLASS_BITS-1:0] CLASS_TWO_HUMPS = 2'd1;
   localparam logic [CLASS_BITS-1:0] CLASS_TAIL      = 2'd2;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [DIFF_BITS-1:0] diff_type;

endpackage

`default_nettype wire

### hdl/csc_req_if.sv
// Request channel of the curve shape classifier: one sample per request.
// Depends on csc_pkg.
`default_nettype none

interface csc_req_if;
   import csc_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [SAMPLE_IN_BITS-1:0] sample;
   logic                      last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink (input valid, input sample, input last_sample, output ready);
endinterface

`default_nettype wire

### hdl/csc_rsp_if.sv
// Response channel of the curve shape classifier: one class per curve.
// Depends on csc_pkg.
`default_nettype none

interface csc_rsp_if;
   import csc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CLASS_BITS-1:0] curve_class;
   logic                  overflowed;

   modport source (output valid, output curve_class, output overflowed, input ready);
   modport sink (input valid, input curve_class, input overflowed, output ready);
endinterface

`default_nettype wire

### hdl/csc_ram.sv
// Generic RAM with one write port and two registered read ports.
// No dependencies.
`default_nettype none

module csc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

`default_nettype wire

### hdl/curve_shape_classifier_core.sv
// Curve shape classifier. Samples load at one per cycle; after the last one
// a sequencer drives one subtractor over the sample RAM, each step an address
// state, then a compare on the registered read data. The drop search, tail
// check and slope walk run before the response is registered. No requests
// are taken during that pass, and the finish state stalls while an earlier
// response still waits. Synchronous reset clears the control state only.
`default_nettype none

module curve_shape_classifier_core (
   input wire logic clock,
   input wire logic reset,
   csc_req_if.sink  req_chan,
   csc_rsp_if.source rsp_chan
);
   import csc_pkg::*;

   localparam logic [2:0] ST_LOAD    = 3'd0;
   localparam logic [2:0] ST_DROP_RD = 3'd1;
   localparam logic [2:0] ST_DROP_EV = 3'd2;
   localparam logic [2:0] ST_TAIL_RD = 3'd3;
   localparam logic [2:0] ST_TAIL_EV = 3'd4;
   localparam logic [2:0] ST_HUMP_RD = 3'd5;
   localparam logic [2:0] ST_HUMP_EV = 3'd6;
   localparam logic [2:0] ST_FINISH  = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   logic [COUNT_BITS-1:0] idx_ff, idx_in;
   logic [COUNT_BITS-1:0] span_ff, span_in;
   logic [1:0]            phase_ff, phase_in;
   diff_type              prev_ff, prev_in;
   logic [CLASS_BITS-1:0] cls_ff, cls_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CLASS_BITS-1:0] rsp_class_ff, rsp_class_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   logic                  accept;
   logic                  full;
   logic                  wr_en;
   logic [WIDE_BITS-1:0]  idx_wide;
   logic [WIDE_BITS-1:0]  n_wide;
   logic [WIDE_BITS-1:0]  addr_a_wide;
   logic [WIDE_BITS-1:0]  addr_b_wide;
   sample_type            rd_a;
   sample_type            rd_b;
   diff_type              diff;

   assign accept = req_chan.valid && req_chan.ready;
   assign full   = (count_ff == COUNT_BITS'(MAX_SAMPLES));
   assign wr_en  = accept && !full;

   assign req_chan.ready       = (state_ff == ST_LOAD);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.curve_class = rsp_class_ff;
   assign rsp_chan.overflowed  = rsp_ovf_ff;

   assign idx_wide = {1'b0, idx_ff};
   assign n_wide   = {1'b0, count_ff};

   // Port A carries the later sample of each pair, port B the earlier one.
   always_comb begin
      case (state_ff)
         ST_DROP_RD: begin
            addr_a_wide = idx_wide + WIDE_BITS'(1);
            addr_b_wide = idx_wide;
         end
         ST_TAIL_RD: begin
            addr_a_wide = idx_wide;
            addr_b_wide = idx_wide - WIDE_BITS'(1);
         end
         ST_HUMP_RD: begin
            addr_a_wide = idx_wide + WIDE_BITS'(SLOPE_SPAN);
            addr_b_wide = idx_wide;
         end
         default: begin
            addr_a_wide = idx_wide;
            addr_b_wide = idx_wide;
         end
      endcase
   end

   csc_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_SAMPLES)
   ) u_sample_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (count_ff[ADDR_BITS-1:0]),
      .wr_data   (req_chan.sample[SAMPLE_BITS-1:0]),
      .rd_addr_a (addr_a_wide[ADDR_BITS-1:0]),
      .rd_addr_b (addr_b_wide[ADDR_BITS-1:0]),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // The one shared subtractor: a drop test, a rise test or a window slope.
   assign diff = $signed({1'b0, rd_a}) - $signed({1'b0, rd_b});

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      idx_in       = idx_ff;
      span_in      = span_ff;
      phase_in     = phase_ff;
      prev_in      = prev_ff;
      cls_in       = cls_ff;
      rsp_class_in = rsp_class_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + COUNT_BITS'(1);
               end
               if (req_chan.last_sample) begin
                  idx_in   = '0;
                  state_in = ST_DROP_RD;
               end
            end
         end
         ST_DROP_RD: begin
            if (idx_wide + WIDE_BITS'(SLOPE_SPAN) < n_wide) begin
               state_in = ST_DROP_EV;
            end else begin
               // No drop: slopes cover everything that has a full window.
               if (n_wide > WIDE_BITS'(SLOPE_SPAN)) begin
                  span_in = count_ff - COUNT_BITS'(SLOPE_SPAN);
                  idx_in  = count_ff - COUNT_BITS'(SLOPE_SPAN - 1);
               end else begin
                  span_in = '0;
                  idx_in  = COUNT_BITS'(1);
               end
               state_in = ST_TAIL_RD;
            end
         end
         ST_DROP_EV: begin
            if (diff < 0) begin
               span_in  = idx_ff;
               idx_in   = idx_ff + COUNT_BITS'(2);
               state_in = ST_TAIL_RD;
            end else begin
               idx_in   = idx_ff + COUNT_BITS'(1);
               state_in = ST_DROP_RD;
            end
         end
         ST_TAIL_RD: begin
            if (idx_ff < count_ff) begin
               state_in = ST_TAIL_EV;
            end else begin
               idx_in   = '0;
               phase_in = 2'd0;
               state_in = ST_HUMP_RD;
            end
         end
         ST_TAIL_EV: begin
            if (diff > 0) begin
               cls_in   = CLASS_TAIL;
               state_in = ST_FINISH;
            end else begin
               idx_in   = idx_ff + COUNT_BITS'(1);
               state_in = ST_TAIL_RD;
            end
         end
         ST_HUMP_RD: begin
            if ((idx_ff < span_ff) && (phase_ff != 2'd3)) begin
               state_in = ST_HUMP_EV;
            end else begin
               cls_in   = (phase_ff == 2'd3) ? CLASS_TWO_HUMPS : CLASS_ONE_HUMP;
               state_in = ST_FINISH;
            end
         end
         ST_HUMP_EV: begin
            // Descent, then rise, then descent of successive slopes.
            if (idx_ff != '0) begin
               if (phase_ff == 2'd1) begin
                  if (prev_ff < diff) begin
                     phase_in = 2'd2;
                  end
               end else if (prev_ff > diff) begin
                  phase_in = phase_ff + 2'd1;
               end
            end
            prev_in  = diff;
            idx_in   = idx_ff + COUNT_BITS'(1);
            state_in = ST_HUMP_RD;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_class_in = cls_ff;
               rsp_ovf_in   = ovf_ff;
               count_in     = '0;
               ovf_in       = 1'b0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         phase_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      span_ff      <= span_in;
      prev_ff      <= prev_in;
      cls_ff       <= cls_in;
      rsp_class_ff <= rsp_class_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

endmodule

`default_nettype wire

### tb/curve_shape_classifier_core_tb.sv
// Testbench for the curve shape classifier: directed curves from a table, then random
// curves, each response checked against a local classifier or a class from the table.
// Depends on csc_pkg and the csc_req_if / csc_rsp_if interfaces.
`timescale 1ns / 1ps

module curve_shape_classifier_core_tb;
   import csc_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 1200;
   localparam int DRAIN_CYCLES  = 2 * MAX_SAMPLES + 60;
   localparam int DIRECTED_ROWS = 20;

   typedef logic [SAMPLE_IN_BITS-1:0] sample_q_type[$];

   typedef struct {
      logic [CLASS_BITS-1:0] curve_class;
      logic                  overflowed;
   } shape_result_type;

   // One row sends the same sample reps times; last_sample applies to the final one.
   typedef struct {
      logic [SAMPLE_IN_BITS-1:0] value;
      logic                      last;
      int                        reps;
      bit                        typed;
      logic [CLASS_BITS-1:0]     curve_class;
      logic                      overflowed;
   } stim_row_type;

   logic clock;
   logic reset;

   csc_req_if req_chan ();
   csc_rsp_if rsp_chan ();

   curve_shape_classifier_core u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   logic [SAMPLE_BITS-1:0] curve_mem [MAX_SAMPLES];
   int                     curve_len;
   logic                   curve_ovf;
   shape_result_type       pending_shapes[$];
   int                     mismatch_count;
   int                     cycle_count;
   int                     random_sent;
   bit                     calm_stretch;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{16'hFFFF, 1'b1,  1, 1'b1, CLASS_ONE_HUMP, 1'b0},
      '{16'h0000, 1'b0,  1, 1'b0, CLASS_ONE_HUMP, 1'b0},
      '{16'hFFFF, 1'b1,  1, 1'b1, CLASS_TAIL,     1'b0},
      '{16'hFFFF, 1'b0,  1, 1'b0, CLASS_ONE_HUMP, 1'b0},
      '{16'h0000, 1'b1,  1, 1'b1, CLASS_ONE_HUMP, 1'b0},
      // A flat curve that runs past the store; the marked sample is dropped too.
      '{16'h1234, 1'b0, 70, 1'b0, CLASS_ONE_HUMP, 1'b0},
      '{16'h0000, 1'b1,  1, 1'b1, CLASS_ONE_HUMP, 1'b1},
      '{16'h0005, 1'b1,  1, 1'b1, CLASS_ONE_HUMP, 1'b0},
      // Staircase whose window slopes fall, rise and fall before the drop.
      '{16'h0000, 1'b0,  1, 1'b0, CLASS_ONE_HUMP, 1'b0},
      '{16'h4000, 1'b0,  2, 1'b0, CLASS_ONE_HUMP, 1'b0},
      '{16'h8000, 1'b0,  3, 1'b0, CLASS_ONE_HUMP, 1'b0},
      '{16'hC000, 1'b0,  3, 1'b0, CLASS_ONE_HUMP, 1'b0},
      '{16'h0000, 1'b0,  3, 1'b0, CLASS_ONE_HUMP, 1'b0},
      '{16'h0000, 1'b1,  1, 1'b0, CLASS_ONE_HUMP, 1'b0},
      // Early drop followed by a rise two samples later.
      '{16'h0100, 1'b0,  1, 1'b0, CLASS_ONE_HUMP, 1'b0},
      '{16'h0200, 1'b0,  1, 1'b0, CLASS_ONE_HUMP, 1'b0},
      '{16'h0050, 1'b0,  1, 1'b0, CLASS_ONE_HUMP, 1'b0},
      '{16'h0040, 1'b0,  1, 1'b0, CLASS_ONE_HUMP, 1'b0},
      '{16'h0060, 1'b0,  1, 1'b0, CLASS_ONE_HUMP, 1'b0},
      '{16'h0010, 1'b1,  1, 1'b0, CLASS_ONE_HUMP, 1'b0}
   };

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic bit take_break();
      return !calm_stretch && ($urandom_range(0, 99) < 27);
   endfunction

   function automatic logic [CLASS_BITS-1:0] classify_stored_curve(int n);
      int  b;
      int  m;
      int  rise_from;
      int  j;
      int  phase;
      int  prev_slope;
      int  cur_slope;
      bit  dropped;
      b       = 0;
      dropped = 1'b0;
      while (!dropped && b < n - SLOPE_SPAN) begin
         if (curve_mem[b] > curve_mem[b+1]) begin
            dropped = 1'b1;
         end else begin
            b++;
         end
      end
      if (dropped) begin
         m         = b;
         rise_from = b + 2;
      end else begin
         m         = (n > SLOPE_SPAN) ? n - SLOPE_SPAN : 0;
         rise_from = m + 1;
      end
      for (j = rise_from; j < n; j++) begin
         if (curve_mem[j] > curve_mem[j-1]) begin
            return CLASS_TAIL;
         end
      end
      // Phase counts the pattern found so far: descent, then rise, then descent.
      phase = 0;
      for (j = 1; j < m && phase < 3; j++) begin
         prev_slope = int'(curve_mem[j-1+SLOPE_SPAN]) - int'(curve_mem[j-1]);
         cur_slope  = int'(curve_mem[j+SLOPE_SPAN]) - int'(curve_mem[j]);
         if (phase == 1) begin
            if (prev_slope < cur_slope) begin
               phase = 2;
            end
         end else if (prev_slope > cur_slope) begin
            phase++;
         end
      end
      return (phase == 3) ? CLASS_TWO_HUMPS : CLASS_ONE_HUMP;
   endfunction

   function automatic void absorb_sample(logic [SAMPLE_IN_BITS-1:0] value, logic last,
                                         bit typed, logic [CLASS_BITS-1:0] cls, logic ovf);
      shape_result_type want;
      if (curve_len < MAX_SAMPLES) begin
         curve_mem[curve_len] = value[SAMPLE_BITS-1:0];
         curve_len++;
      end else begin
         curve_ovf = 1'b1;
      end
      if (last) begin
         want.curve_class = classify_stored_curve(curve_len);
         want.overflowed  = curve_ovf;
         if (typed) begin
            want.curve_class = cls;
            want.overflowed  = ovf;
         end
         pending_shapes.push_back(want);
         curve_len = 0;
         curve_ovf = 1'b0;
      end
   endfunction

   task automatic send_sample(logic [SAMPLE_IN_BITS-1:0] value, logic last, bit typed,
                              logic [CLASS_BITS-1:0] cls, logic ovf);
      while (take_break()) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.sample      <= value;
      req_chan.last_sample <= last;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      absorb_sample(value, last, typed, cls, ovf);
   endtask

   // Mostly a rise up to a random peak and a fall after it; some curves are pure noise,
   // some are short, some overrun the store, and some have one sample overwritten.
   function automatic sample_q_type build_curve();
      sample_q_type vals;
      int           kind;
      int           n;
      int           b;
      int           k;
      int           step_cap;
      int           level;
      int           step;
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
         n = $urandom_range(1, SLOPE_SPAN + 1);
         for (k = 0; k < n; k++) vals.push_back(SAMPLE_IN_BITS'($urandom_range(0, 65535)));
      end else if (kind < 25) begin
         n = $urandom_range(1, 40);
         for (k = 0; k < n; k++) vals.push_back(SAMPLE_IN_BITS'($urandom_range(0, 65535)));
      end else begin
         n        = (kind < 32) ? $urandom_range(MAX_SAMPLES - 4, MAX_SAMPLES + 12)
                                : $urandom_range(6, 28);
         b        = $urandom_range(0, n - 1);
         step_cap = 1 << $urandom_range(0, 13);
         level    = $urandom_range(0, 65535) >> $urandom_range(0, 16);
         for (k = 0; k < n; k++) begin
            if (k > 0) begin
               step = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, step_cap);
               if (k <= b) begin
                  level = (level + step > 65535) ? 65535 : level + step;
               end else begin
                  level = (level < step) ? 0 : level - step;
               end
            end
            vals.push_back(level[SAMPLE_IN_BITS-1:0]);
         end
         if ($urandom_range(0, 3) == 0) begin
            vals[$urandom_range(0, n - 1)] = SAMPLE_IN_BITS'($urandom_range(0, 65535));
         end
      end
      return vals;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= !take_break();
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_shapes.size() == 0) begin
               $display("%0t: response with none expected, class %0d overflowed %0b",
                        $time, rsp_chan.curve_class, rsp_chan.overflowed);
               mismatch_count++;
            end else begin
               if (rsp_chan.curve_class !== pending_shapes[0].curve_class) begin
                  $display("%0t: curve_class mismatch, expected %0d, actual %0d", $time,
                           pending_shapes[0].curve_class, rsp_chan.curve_class);
                  mismatch_count++;
               end
               if (rsp_chan.overflowed !== pending_shapes[0].overflowed) begin
                  $display("%0t: overflowed mismatch, expected %0b, actual %0b", $time,
                           pending_shapes[0].overflowed, rsp_chan.overflowed);
                  mismatch_count++;
               end
               void'(pending_shapes.pop_front());
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time,
                  pending_shapes.size());
         $display("** curve_shape_classifier_core: FAILED **");
         $finish;
      end
   end

   initial begin
      sample_q_type curve;
      int           r;
      int           k;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.sample      = '0;
      req_chan.last_sample = 1'b0;
      rsp_chan.ready       = 1'b0;
      curve_len            = 0;
      curve_ovf            = 1'b0;
      mismatch_count       = 0;
      cycle_count          = 0;
      random_sent          = 0;
      calm_stretch         = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < DIRECTED_ROWS; r++) begin
         for (k = 0; k < directed_rows[r].reps; k++) begin
            send_sample(directed_rows[r].value,
                        directed_rows[r].last && (k == directed_rows[r].reps - 1),
                        directed_rows[r].typed, directed_rows[r].curve_class,
                        directed_rows[r].overflowed);
         end
      end

      while (random_sent < RANDOM_ITEMS) begin
         // A window of the run goes without any idle cycles on either side.
         calm_stretch = (random_sent >= 500 && random_sent < 700);
         curve = build_curve();
         for (k = 0; k < curve.size(); k++) begin
            send_sample(curve[k], k == curve.size() - 1, 1'b0, CLASS_ONE_HUMP, 1'b0);
            random_sent++;
         end
      end
      calm_stretch = 1'b0;
      req_chan.valid <= 1'b0;

      while (pending_shapes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** curve_shape_classifier_core: PASSED **");
      end else begin
         $display("** curve_shape_classifier_core: FAILED **");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/csc_pkg.sv
hdl/csc_req_if.sv
hdl/csc_rsp_if.sv
hdl/csc_ram.sv
hdl/curve_shape_classifier_core.sv
tb/curve_shape_classifier_core_tb.sv
